[rtl/keyframe_spline_interpolator_top_assert.svh]
// ----------------------------------------------------------------------------
// keyframe spline interpolator assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_SPLINE_INTERPOLATOR_TOP_ASSERT_SVH
`define KEYFRAME_SPLINE_INTERPOLATOR_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define KSI_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ksi check failed");

// next-cycle implication, disabled in reset
`define KSI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ksi check failed");

`endif

[rtl/ksi_pkg.sv]
// ----------------------------------------------------------------------------
// ksi_pkg
// types, constants and arithmetic helpers of the keyframe spline interpolator
// ----------------------------------------------------------------------------
package ksi_pkg;

    localparam int MAX_KEYS  = 64;
    localparam int FRAC_BITS = 16;
    localparam int ADDR_W    = $clog2(MAX_KEYS);
    localparam int CNT_W     = $clog2(MAX_KEYS + 1);
    localparam int VAL_W     = 32;
    localparam int SPAN_W    = 34;            // sum of three 33-bit magnitudes
    localparam int TOL_SHIFT = 20;
    localparam int T_W       = FRAC_BITS + 1; // segment fraction, up to 1.0
    localparam int P_W       = 34;            // control point incl. extrapolation
    localparam int H_W       = 42;            // spline intermediates
    localparam int PROD_W    = H_W + T_W + 1;

    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_SPLINE = 2'd2;
    localparam logic [1:0] KIND_LINEAR = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;
    localparam logic [1:0] STATUS_ORDER = 2'd3;

    localparam logic [1:0] COMP_X     = 2'd0;
    localparam logic [1:0] COMP_Y     = 2'd1;
    localparam logic [1:0] COMP_Z     = 2'd2;
    localparam logic [1:0] COMP_ANGLE = 2'd3;

    typedef struct packed {
        logic signed [VAL_W-1:0] angle;
        logic signed [VAL_W-1:0] pos_z;
        logic signed [VAL_W-1:0] pos_y;
        logic signed [VAL_W-1:0] pos_x;
        logic signed [VAL_W-1:0] time_req;
    } key_row_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_APP_DIFF,
        ST_APP_SPAN,
        ST_APP_CLOSE,
        ST_Q_START,
        ST_CLAMP,
        ST_SCAN,
        ST_FETCH,
        ST_DIV,
        ST_NBR,
        ST_COEF,
        ST_MUL,
        ST_ACC,
        ST_FIN,
        ST_DONE
    } state_t;

    function automatic logic signed [VAL_W-1:0] field_of(input key_row_t row,
                                                         input logic [1:0] comp);
        logic signed [VAL_W-1:0] v;
        case (comp)
            COMP_X:  v = row.pos_x;
            COMP_Y:  v = row.pos_y;
            COMP_Z:  v = row.pos_z;
            default: v = row.angle;
        endcase
        return v;
    endfunction

    // round half away from zero, shift by FRAC_BITS
    function automatic logic signed [H_W-1:0] rnd_frac(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] mag;
        logic signed [PROD_W-1:0] sh;
        mag = v[PROD_W-1] ? -v : v;
        sh  = (mag + (PROD_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (v[PROD_W-1]) begin
            sh = -sh;
        end
        return sh[H_W-1:0];
    endfunction

    // round half away from zero, shift by one
    function automatic logic signed [H_W-1:0] rnd_half(input logic signed [H_W-1:0] v);
        logic signed [H_W-1:0] mag;
        logic signed [H_W-1:0] sh;
        mag = v[H_W-1] ? -v : v;
        sh  = (mag + H_W'(1)) >>> 1;
        if (v[H_W-1]) begin
            sh = -sh;
        end
        return sh;
    endfunction

    function automatic logic [VAL_W-1:0] sat32(input logic signed [H_W-1:0] v);
        logic [VAL_W-1:0] r;
        if (v > H_W'(signed'(33'sh0_7FFF_FFFF))) begin
            r = {1'b0, {(VAL_W-1){1'b1}}};
        end else if (v < H_W'(signed'(-33'sh0_8000_0000))) begin
            r = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

endpackage

[rtl/keyframe_spline_interpolator_top.sv]
// ----------------------------------------------------------------------------
// keyframe_spline_interpolator_top
// keyframe table with catmull-rom and linear pose queries, q16.16
// ----------------------------------------------------------------------------
// usage:
//   s_ channel carries one item per transaction: s_tuser is the kind (clear,
//   append, spline query, linear query), s_tdata the key time or query time
//   and the key pose. every item gives exactly one result transaction on m_.
//   m_tdata carries the saturated pose (zero for clear, append and errors),
//   m_tuser the closed-path flag and the status code.
// operation:
//   one item at a time. clear, rejected append and empty-table query go
//   straight to the result; an accepted append passes the diff, span and
//   close states; a clamped query reads its end key. an interior query
//   walks the key memory one key per cycle to find its segment, then
//   reads four keys, runs a radix-2 divider and evaluates four components
//   on one shared multiplier. the single read port of the key memory sets
//   the search time.
// reset:
//   aresetn low empties the table and drops any result in flight. the key
//   memory is not cleared; only entries below the key count are read.
// stalls:
//   a result is held in the output register until m_tready; the next item
//   can be taken meanwhile, and its finished result waits for the register.
// ----------------------------------------------------------------------------
module keyframe_spline_interpolator_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [159:0] s_tdata,   // time_req, pos_x, pos_y, pos_z, angle
    input  logic [1:0]   s_tuser,   // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // out_x, out_y, out_z, out_angle
    output logic [2:0]   m_tuser    // is_closed, status
);

    localparam int ADDR_W = ksi_pkg::ADDR_W;
    localparam int CNT_W  = ksi_pkg::CNT_W;
    localparam int VAL_W  = ksi_pkg::VAL_W;
    localparam int SPAN_W = ksi_pkg::SPAN_W;
    localparam int T_W    = ksi_pkg::T_W;
    localparam int P_W    = ksi_pkg::P_W;
    localparam int H_W    = ksi_pkg::H_W;
    localparam int PROD_W = ksi_pkg::PROD_W;

    // key memory, one row per key
    ksi_pkg::key_row_t key_mem [ksi_pkg::MAX_KEYS];
    ksi_pkg::key_row_t rdata_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              mem_we;

    ksi_pkg::state_t state_reg, state_next;

    // table summary
    logic [CNT_W-1:0]        count_reg;
    logic [SPAN_W-1:0]       far_span_reg;
    logic                    closed_reg;
    logic signed [VAL_W-1:0] time0_reg, last_time_reg;
    logic signed [VAL_W-1:0] x0_reg, y0_reg, z0_reg;

    // item in work
    ksi_pkg::key_row_t in_row_reg;
    logic [1:0]        status_reg;
    logic              lin_reg;
    logic [VAL_W:0]    dx_reg, dy_reg, dz_reg;

    // search and divide
    logic [CNT_W-1:0]        idx_reg;
    logic signed [VAL_W-1:0] prev_time_reg;
    logic [ADDR_W-1:0]       k_reg;
    logic [2:0]              fc_reg;
    logic [SPAN_W-1:0]       rem_reg;
    logic [VAL_W:0]          span_reg;
    logic [T_W-1:0]          q_reg;
    logic [4:0]              div_cnt_reg;

    // evaluation
    ksi_pkg::key_row_t       row_reg [4];
    logic [1:0]              comp_reg;
    logic [1:0]              stg_reg;
    logic signed [P_W-1:0]   p0_reg, p1_reg, p2_reg, p3_reg;
    logic signed [H_W-1:0]   a_reg, b_reg, c_reg, h_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [3:0][VAL_W-1:0]   res_reg;

    // output register
    logic         m_tvalid_reg;
    logic [127:0] m_tdata_reg;
    logic [2:0]   m_tuser_reg;

    // decode of the incoming transaction
    ksi_pkg::key_row_t s_row;
    logic              s_accept;
    logic              tbl_full, order_bad;
    logic [ADDR_W-1:0] last_idx;
    logic              q_low, q_high;
    logic              scan_hit;
    logic [ADDR_W-1:0] p0_addr, p3_addr;
    logic              k_first, k_last;
    logic [SPAN_W-1:0] sum_abs;
    logic [SPAN_W-1:0] tol;
    logic [SPAN_W-1:0] div_trial;
    logic              div_bit;
    logic              out_free;

    assign s_row     = ksi_pkg::key_row_t'(s_tdata);
    assign s_accept  = s_tvalid && s_tready;
    assign tbl_full  = (count_reg == CNT_W'(ksi_pkg::MAX_KEYS));
    assign order_bad = (count_reg != '0) && (s_row.time_req < last_time_reg);
    assign last_idx  = ADDR_W'(count_reg - 1'b1);
    assign q_low     = (in_row_reg.time_req <= time0_reg);
    assign q_high    = (in_row_reg.time_req >= last_time_reg);
    assign scan_hit  = (rdata_reg.time_req >= in_row_reg.time_req);
    assign k_first   = (k_reg == '0);
    assign k_last    = (ADDR_W'(k_reg + 1'b1) == last_idx);
    // wrapped neighbours come from the opposite inner key
    assign p0_addr   = k_first ? ADDR_W'(last_idx - 1'b1) : ADDR_W'(k_reg - 1'b1);
    assign p3_addr   = k_last  ? ADDR_W'(1) : ADDR_W'(k_reg + 2'd2);
    assign sum_abs   = SPAN_W'(dx_reg) + SPAN_W'(dy_reg) + SPAN_W'(dz_reg);
    assign tol       = ((far_span_reg >> ksi_pkg::TOL_SHIFT) == '0) ? SPAN_W'(1)
                       : (far_span_reg >> ksi_pkg::TOL_SHIFT);
    assign div_bit   = (rem_reg >= SPAN_W'(span_reg));
    assign div_trial = div_bit ? (rem_reg - SPAN_W'(span_reg)) : rem_reg;
    assign out_free  = !m_tvalid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ksi_pkg::ST_IDLE: begin
                if (s_accept) begin
                    if (s_tuser == ksi_pkg::KIND_CLEAR) begin
                        state_next = ksi_pkg::ST_DONE;
                    end else if (s_tuser == ksi_pkg::KIND_APPEND) begin
                        state_next = (tbl_full || order_bad) ? ksi_pkg::ST_DONE
                                                             : ksi_pkg::ST_APP_DIFF;
                    end else begin
                        state_next = (count_reg == '0) ? ksi_pkg::ST_DONE
                                                       : ksi_pkg::ST_Q_START;
                    end
                end
            end
            ksi_pkg::ST_APP_DIFF:  state_next = ksi_pkg::ST_APP_SPAN;
            ksi_pkg::ST_APP_SPAN:  state_next = ksi_pkg::ST_APP_CLOSE;
            ksi_pkg::ST_APP_CLOSE: state_next = ksi_pkg::ST_DONE;
            ksi_pkg::ST_Q_START: begin
                state_next = (q_low || q_high) ? ksi_pkg::ST_CLAMP : ksi_pkg::ST_SCAN;
            end
            ksi_pkg::ST_CLAMP: state_next = ksi_pkg::ST_DONE;
            ksi_pkg::ST_SCAN: begin
                if (scan_hit) begin
                    state_next = ksi_pkg::ST_FETCH;
                end
            end
            ksi_pkg::ST_FETCH: begin
                if (fc_reg == 3'd4) begin
                    state_next = ksi_pkg::ST_DIV;
                end
            end
            ksi_pkg::ST_DIV: begin
                if (div_cnt_reg == 5'(T_W - 1)) begin
                    state_next = ksi_pkg::ST_NBR;
                end
            end
            ksi_pkg::ST_NBR: state_next = ksi_pkg::ST_COEF;
            ksi_pkg::ST_COEF: state_next = ksi_pkg::ST_MUL;
            ksi_pkg::ST_MUL:  state_next = ksi_pkg::ST_ACC;
            ksi_pkg::ST_ACC: begin
                if (lin_reg) begin
                    state_next = (comp_reg == ksi_pkg::COMP_ANGLE) ? ksi_pkg::ST_DONE
                                                                   : ksi_pkg::ST_NBR;
                end else if (stg_reg == 2'd2) begin
                    state_next = ksi_pkg::ST_FIN;
                end else begin
                    state_next = ksi_pkg::ST_MUL;
                end
            end
            ksi_pkg::ST_FIN: begin
                state_next = (comp_reg == ksi_pkg::COMP_ANGLE) ? ksi_pkg::ST_DONE
                                                               : ksi_pkg::ST_NBR;
            end
            ksi_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = ksi_pkg::ST_IDLE;
                end
            end
            default: state_next = ksi_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_tready = 1'b0;
        mem_we   = 1'b0;
        rd_addr  = '0;
        unique case (state_reg)
            ksi_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                mem_we   = s_tvalid && (s_tuser == ksi_pkg::KIND_APPEND) &&
                           !tbl_full && !order_bad;
            end
            ksi_pkg::ST_Q_START: begin
                if (q_low) begin
                    rd_addr = '0;
                end else if (q_high) begin
                    rd_addr = last_idx;
                end else begin
                    rd_addr = ADDR_W'(1);
                end
            end
            ksi_pkg::ST_SCAN: rd_addr = ADDR_W'(idx_reg + 1'b1);
            ksi_pkg::ST_FETCH: begin
                case (fc_reg)
                    3'd0:    rd_addr = p0_addr;
                    3'd1:    rd_addr = k_reg;
                    3'd2:    rd_addr = ADDR_W'(k_reg + 1'b1);
                    default: rd_addr = p3_addr;
                endcase
            end
            default: rd_addr = '0;
        endcase
    end

    // key memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            key_mem[count_reg[ADDR_W-1:0]] <= s_row;
        end
        rdata_reg <= key_mem[rd_addr];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ksi_pkg::ST_IDLE;
            count_reg    <= '0;
            far_span_reg <= '0;
            closed_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ksi_pkg::ST_IDLE && s_accept &&
                s_tuser == ksi_pkg::KIND_CLEAR) begin
                count_reg    <= '0;
                far_span_reg <= '0;
                closed_reg   <= 1'b0;
            end
            if (mem_we) begin
                count_reg <= CNT_W'(count_reg + 1'b1);
            end
            if (state_reg == ksi_pkg::ST_APP_SPAN && sum_abs > far_span_reg) begin
                far_span_reg <= sum_abs;
            end
            if (state_reg == ksi_pkg::ST_APP_CLOSE) begin
                closed_reg <= (count_reg >= CNT_W'(3)) &&
                              (SPAN_W'(dx_reg) <= tol) &&
                              (SPAN_W'(dy_reg) <= tol) &&
                              (SPAN_W'(dz_reg) <= tol);
            end
            if (state_reg == ksi_pkg::ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        logic signed [P_W-1:0]   v0, v1, v2, v3;
        logic                    wrap;
        logic signed [H_W-1:0]   r;
        logic signed [VAL_W+1:0] off;
        v0   = P_W'(ksi_pkg::field_of(row_reg[0], comp_reg));
        v1   = P_W'(ksi_pkg::field_of(row_reg[1], comp_reg));
        v2   = P_W'(ksi_pkg::field_of(row_reg[2], comp_reg));
        v3   = P_W'(ksi_pkg::field_of(row_reg[3], comp_reg));
        wrap = closed_reg && (comp_reg != ksi_pkg::COMP_ANGLE);
        r    = ksi_pkg::rnd_frac(prod_reg);
        off  = (VAL_W+2)'(in_row_reg.time_req) - (VAL_W+2)'(prev_time_reg);

        unique case (state_reg)
            ksi_pkg::ST_IDLE: begin
                if (s_accept) begin
                    in_row_reg <= s_row;
                    lin_reg    <= (s_tuser == ksi_pkg::KIND_LINEAR) ||
                                  (count_reg < CNT_W'(3));
                    res_reg    <= '0;
                    status_reg <= ksi_pkg::STATUS_OK;
                    if (s_tuser == ksi_pkg::KIND_APPEND) begin
                        if (tbl_full) begin
                            status_reg <= ksi_pkg::STATUS_FULL;
                        end else if (order_bad) begin
                            status_reg <= ksi_pkg::STATUS_ORDER;
                        end else begin
                            last_time_reg <= s_row.time_req;
                            if (count_reg == '0) begin
                                time0_reg <= s_row.time_req;
                                x0_reg    <= s_row.pos_x;
                                y0_reg    <= s_row.pos_y;
                                z0_reg    <= s_row.pos_z;
                            end
                        end
                    end else if (s_tuser != ksi_pkg::KIND_CLEAR && count_reg == '0) begin
                        status_reg <= ksi_pkg::STATUS_EMPTY;
                    end
                end
            end
            ksi_pkg::ST_APP_DIFF: begin
                dx_reg <= (in_row_reg.pos_x >= x0_reg)
                        ? (VAL_W+1)'(in_row_reg.pos_x) - (VAL_W+1)'(x0_reg)
                        : (VAL_W+1)'(x0_reg) - (VAL_W+1)'(in_row_reg.pos_x);
                dy_reg <= (in_row_reg.pos_y >= y0_reg)
                        ? (VAL_W+1)'(in_row_reg.pos_y) - (VAL_W+1)'(y0_reg)
                        : (VAL_W+1)'(y0_reg) - (VAL_W+1)'(in_row_reg.pos_y);
                dz_reg <= (in_row_reg.pos_z >= z0_reg)
                        ? (VAL_W+1)'(in_row_reg.pos_z) - (VAL_W+1)'(z0_reg)
                        : (VAL_W+1)'(z0_reg) - (VAL_W+1)'(in_row_reg.pos_z);
            end
            ksi_pkg::ST_Q_START: begin
                idx_reg       <= CNT_W'(1);
                prev_time_reg <= time0_reg;
            end
            ksi_pkg::ST_CLAMP: begin
                res_reg <= {rdata_reg.angle, rdata_reg.pos_z,
                            rdata_reg.pos_y, rdata_reg.pos_x};
            end
            ksi_pkg::ST_SCAN: begin
                // first key at or after the query time closes the segment
                if (scan_hit) begin
                    k_reg    <= ADDR_W'(idx_reg - 1'b1);
                    span_reg <= (VAL_W+1)'(rdata_reg.time_req) - (VAL_W+1)'(prev_time_reg);
                    rem_reg  <= SPAN_W'(off);
                    fc_reg   <= '0;
                end else begin
                    idx_reg       <= CNT_W'(idx_reg + 1'b1);
                    prev_time_reg <= rdata_reg.time_req;
                end
            end
            ksi_pkg::ST_FETCH: begin
                fc_reg <= 3'(fc_reg + 1'b1);
                case (fc_reg)
                    3'd1:    row_reg[0] <= rdata_reg;
                    3'd2:    row_reg[1] <= rdata_reg;
                    3'd3:    row_reg[2] <= rdata_reg;
                    3'd4:    row_reg[3] <= rdata_reg;
                    default: ;
                endcase
                q_reg       <= '0;
                div_cnt_reg <= '0;
            end
            ksi_pkg::ST_DIV: begin
                // restoring division, one quotient bit per cycle
                rem_reg     <= SPAN_W'({div_trial, 1'b0});
                q_reg       <= {q_reg[T_W-2:0], div_bit};
                div_cnt_reg <= 5'(div_cnt_reg + 1'b1);
                comp_reg    <= ksi_pkg::COMP_X;
            end
            ksi_pkg::ST_NBR: begin
                if (span_reg == '0) begin
                    q_reg <= '0;
                end
                p1_reg <= v1;
                p2_reg <= v2;
                p0_reg <= (k_first && !wrap) ? P_W'((v1 <<< 1) - v2) : v0;
                p3_reg <= (k_last  && !wrap) ? P_W'((v2 <<< 1) - v1) : v3;
            end
            ksi_pkg::ST_COEF: begin
                a_reg   <= H_W'(p1_reg) <<< 1;
                b_reg   <= H_W'(p2_reg) - H_W'(p0_reg);
                c_reg   <= (H_W'(p0_reg) <<< 1) - H_W'(p1_reg) * H_W'(5)
                           + (H_W'(p2_reg) <<< 2) - H_W'(p3_reg);
                h_reg   <= lin_reg ? H_W'(p2_reg) - H_W'(p1_reg)
                           : H_W'(p3_reg) - H_W'(p0_reg)
                             + H_W'(p1_reg) * H_W'(3) - H_W'(p2_reg) * H_W'(3);
                stg_reg <= '0;
            end
            ksi_pkg::ST_MUL: begin
                prod_reg <= PROD_W'($signed({1'b0, q_reg}) * h_reg);
            end
            ksi_pkg::ST_ACC: begin
                stg_reg <= 2'(stg_reg + 1'b1);
                if (lin_reg) begin
                    res_reg[comp_reg] <= ksi_pkg::sat32(H_W'(p1_reg) + r);
                    comp_reg          <= 2'(comp_reg + 1'b1);
                end else begin
                    case (stg_reg)
                        2'd0:    h_reg <= c_reg + r;
                        2'd1:    h_reg <= b_reg + r;
                        default: h_reg <= r;
                    endcase
                end
            end
            ksi_pkg::ST_FIN: begin
                res_reg[comp_reg] <= ksi_pkg::sat32(ksi_pkg::rnd_half(a_reg + h_reg));
                comp_reg          <= 2'(comp_reg + 1'b1);
            end
            ksi_pkg::ST_DONE: begin
                if (out_free) begin
                    m_tdata_reg <= res_reg;
                    m_tuser_reg <= {status_reg, closed_reg};
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

[rtl/ksi_checker.sv]
// ----------------------------------------------------------------------------
// ksi_checker
// port-level checks of the keyframe spline interpolator
// ----------------------------------------------------------------------------
`include "keyframe_spline_interpolator_top_assert.svh"

module ksi_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic [2:0]   m_tuser
);

    // stalled result holds
    `KSI_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // one item in work at a time
    `KSI_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready)

    // any error status carries a zero pose
    `KSI_ASSERT_NOW(a_err_zero, m_tvalid && m_tuser[2:1] != ksi_pkg::STATUS_OK, m_tdata == '0)

    // an empty table is never a closed path
    `KSI_ASSERT_NOW(a_empty_open, m_tvalid && m_tuser[2:1] == ksi_pkg::STATUS_EMPTY, !m_tuser[0])

endmodule

bind keyframe_spline_interpolator_top ksi_checker u_ksi_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
